// ===== hdl/spid_pkg.sv =====
// Package for the steering PID H-bridge drive core.
// Holds widths, register indexes, mode and status codes, and the sequencer state type.
// No dependencies.
package spid_pkg;

  localparam int POS_BITS = 10;
  localparam int MUL_W    = 32;
  localparam int DIV_N    = 48;
  localparam int DIV_D    = 32;
  localparam int OUT_W    = 48;

  localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [2:0] REG_DEAD_BAND   = 3'd3;
  localparam logic [2:0] REG_INTEG_LIMIT = 3'd4;

  localparam logic [7:0] MODE_PAUSE  = 8'd0;
  localparam logic [7:0] MODE_MANUAL = 8'd1;
  localparam logic [7:0] MODE_AUTO   = 8'd2;

  localparam logic [3:0] STAT_NEUTRAL = 4'd0;
  localparam logic [3:0] STAT_RIGHT   = 4'd1;
  localparam logic [3:0] STAT_LEFT    = 4'd2;
  localparam logic [3:0] STAT_PAUSE   = 4'd3;
  localparam logic [3:0] STAT_AUTO    = 4'd4;
  localparam logic [3:0] STAT_HOLD    = 4'd7;
  localparam logic [3:0] STAT_FAULT   = 4'd8;
  localparam logic [3:0] STAT_NO_LINK = 4'd9;

  localparam logic [19:0] INTEG_MAX = 20'd524287;
  localparam logic [9:0]  MS_PER_S  = 10'd1000;
  localparam logic [7:0]  DUTY_MAX  = 8'd255;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_DT, ST_INTEG, ST_MUL_P, ST_MUL_I, ST_DIV_I,
    ST_MUL_D, ST_DIV_D, ST_SUM, ST_OUT
  } seq_state_t;

endpackage

// ===== hdl/spid_mul.sv =====
// Bit-serial unsigned multiplier, one multiplier bit per cycle.
// Depends on spid_pkg for the operand width.
module spid_mul
  import spid_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [MUL_W-1:0]     a,
  input  logic [MUL_W-1:0]     b,
  output logic                 done,
  output logic [2*MUL_W-1:0]   prod
);

  logic [2*MUL_W-1:0]       acc;
  logic [MUL_W-1:0]         mcand;
  logic [$clog2(MUL_W)-1:0] cnt;
  logic                     busy;
  logic [MUL_W:0]           part;

  // Upper half accumulates; the lower half holds the multiplier bits still to use.
  assign part = {1'b0, acc[2*MUL_W-1:MUL_W]} + (acc[0] ? {1'b0, mcand} : '0);
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == MUL_W[$clog2(MUL_W)-1:0] - 1'b1);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_W[$clog2(MUL_W)-1:0] - 1'b1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= {{MUL_W{1'b0}}, b};
      mcand <= a;
    end else if (busy) begin
      acc <= {part, acc[MUL_W-1:1]};
    end
  end

endmodule

// ===== hdl/spid_div.sv =====
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// Depends on spid_pkg for dividend and divisor widths.
module spid_div
  import spid_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_N-1:0]  dividend,
  input  logic [DIV_D-1:0]  divisor,
  output logic              done,
  output logic [DIV_N-1:0]  quot
);

  logic [DIV_D-1:0]         rem;
  logic [DIV_D-1:0]         dsr;
  logic [$clog2(DIV_N)-1:0] cnt;
  logic                     busy;
  logic [DIV_D:0]           trial;
  logic                     ge;

  assign trial = {rem, quot[DIV_N-1]};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == $clog2(DIV_N)'(DIV_N - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == $clog2(DIV_N)'(DIV_N - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dsr  <= divisor;
      quot <= dividend;
    end else if (busy) begin
      rem  <= ge ? DIV_D'(trial - {1'b0, dsr}) : trial[DIV_D-1:0];
      quot <= {quot[DIV_N-2:0], ge};
    end
  end

endmodule

// ===== hdl/steering_pid_hbridge_drive_core.sv =====
// Top level of the steering PID H-bridge drive core.
// Depends on spid_pkg, spid_mul and spid_div.
//
// One control tick goes in as an item and one result item comes out. Ticks that
// run no PID step (no link, pause, auto hold, unknown mode) go straight to the
// output state. A PID tick computes four products on one bit-serial multiplier
// and two quotients on one bit-serial divider (integral over 1000, and the derivative
// term over the time step; the second is skipped when the time step is zero). The
// block works on one tick at a time; the finished result sits in an output register,
// so the next tick is taken while the result waits for m_tready. The user must write
// gains and limits on the cfg port only while idle; the block does not enforce it.
module steering_pid_hbridge_drive_core
  import spid_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // now_ms[31:0], pot_reading[41:32], link_ok[42], manual_target[58:43],
  // auto_valid[59], auto_target[69:60], zero fill [71:70]
  input  logic [71:0] s_tdata,
  // drive_mode[7:0]
  input  logic [7:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // right_duty[7:0], left_duty[15:8], last_err[32:16], zero fill [39:33]
  output logic [39:0] m_tdata,
  // drive_status[3:0]
  output logic [3:0]  m_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers.
  logic [15:0] prop_gain, integ_gain, deriv_gain;
  logic [9:0]  dead_band, integ_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= 16'd256;
      integ_gain  <= '0;
      deriv_gain  <= '0;
      dead_band   <= 10'd10;
      integ_limit <= 10'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROP_GAIN:   prop_gain   <= cfg_data;
        REG_INTEG_GAIN:  integ_gain  <= cfg_data;
        REG_DERIV_GAIN:  deriv_gain  <= cfg_data;
        REG_DEAD_BAND:   dead_band   <= cfg_data[9:0];
        REG_INTEG_LIMIT: integ_limit <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Input fields.
  logic [31:0]         now_ms;
  logic [POS_BITS-1:0] pot_reading, auto_target;
  logic                link_ok, auto_valid;
  logic signed [15:0]  manual_target;
  logic [7:0]          drive_mode;

  assign now_ms        = s_tdata[31:0];
  assign pot_reading   = POS_BITS'(s_tdata[41:32]);
  assign link_ok       = s_tdata[42];
  assign manual_target = s_tdata[58:43];
  assign auto_valid    = s_tdata[59];
  assign auto_target   = POS_BITS'(s_tdata[69:60]);
  assign drive_mode    = s_tuser;

  // Controller state.
  logic signed [19:0] integ_acc;
  logic signed [16:0] prev_err;
  logic [31:0]        prev_pid_time;

  // Working registers for the tick in progress.
  logic signed [16:0] err_q;
  logic signed [17:0] de_q;
  logic [31:0]        dt_q;
  logic               auto_q;
  logic signed [OUT_W-1:0] term_p, term_i, term_d;
  logic [DIV_N-1:0]   dprod;

  // Result held until the output register is free.
  logic [7:0]         res_right, res_left;
  logic [3:0]         res_status;
  logic signed [16:0] res_err;

  seq_state_t state, state_next;
  logic       op_started;

  logic               in_acc, pid_run;
  logic [3:0]         skip_status;
  logic signed [17:0] setpoint, diff;
  logic signed [16:0] err_new;
  logic [16:0]        err_mag, de_mag;
  logic [19:0]        integ_mag;

  logic                   mul_start, mul_done, div_start, div_done;
  logic [MUL_W-1:0]       mul_a, mul_b;
  logic [2*MUL_W-1:0]     mul_prod;
  logic [DIV_N-1:0]       div_n, div_q;
  logic [DIV_D-1:0]       div_d;
  logic                   out_load;

  assign in_acc = s_tvalid && s_tready;

  // Decide whether the tick runs a PID step, and the status when it does not.
  always_comb begin
    pid_run     = 1'b0;
    skip_status = STAT_FAULT;
    setpoint    = 18'(signed'(manual_target));
    unique case (drive_mode)
      MODE_PAUSE:  skip_status = STAT_PAUSE;
      MODE_MANUAL: pid_run = 1'b1;
      MODE_AUTO: begin
        pid_run     = auto_valid;
        skip_status = STAT_HOLD;
        setpoint    = signed'(18'(auto_target));
      end
      default: ;
    endcase
    if (!link_ok) begin
      pid_run     = 1'b0;
      skip_status = STAT_NO_LINK;
    end
  end

  // Error with saturation to the 17-bit range; only reachable with wide positions.
  assign diff    = setpoint - signed'(18'(pot_reading));
  assign err_new = (diff > 18'sd65535) ? 17'sd65535 :
                   (diff < -18'sd65536) ? -17'sd65536 : diff[16:0];

  assign err_mag   = err_q[16] ? 17'(-err_q) : err_q;
  assign de_mag    = de_q[17] ? 17'(-de_q) : de_q[16:0];
  assign integ_mag = integ_acc[19] ? 20'(-integ_acc) : integ_acc;

  // Integral update: add the signed error-time product and clamp to the limit.
  logic [19:0]        lim_raw, lim;
  logic signed [51:0] isum, prod_s;

  assign lim_raw = {integ_limit, 10'b0} - {6'b0, integ_limit, 4'b0} - {7'b0, integ_limit, 3'b0};
  assign lim     = (lim_raw > INTEG_MAX) ? INTEG_MAX : lim_raw;
  assign prod_s  = err_q[16] ? -signed'({3'b0, mul_prod[48:0]})
                             : signed'({3'b0, mul_prod[48:0]});
  assign isum    = 52'(integ_acc) + prod_s;

  // Output sum and drive magnitude.
  logic signed [OUT_W-1:0] out8;
  logic [OUT_W-1:0]        out_mag;
  logic [7:0]              duty;

  assign out8    = term_p + term_i + term_d;
  assign out_mag = out8[OUT_W-1] ? OUT_W'(-out8) : out8;
  assign duty    = (|out_mag[OUT_W-1:16]) ? DUTY_MAX : out_mag[15:8];

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_acc) state_next = pid_run ? ST_MUL_DT : ST_OUT;
      ST_MUL_DT: if (mul_done) state_next = ST_INTEG;
      ST_INTEG:  state_next = ST_MUL_P;
      ST_MUL_P:  if (mul_done) state_next = ST_MUL_I;
      ST_MUL_I:  if (mul_done) state_next = ST_DIV_I;
      ST_DIV_I:  if (div_done) state_next = ST_MUL_D;
      ST_MUL_D:  if (mul_done) state_next = (dt_q == '0) ? ST_SUM : ST_DIV_D;
      ST_DIV_D:  if (div_done) state_next = ST_SUM;
      ST_SUM:    state_next = ST_OUT;
      ST_OUT:    if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs and operand selection for the shared units.
  always_comb begin
    s_tready  = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_n     = '0;
    div_d     = '0;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_MUL_DT: begin
        mul_start = !op_started;
        mul_a     = dt_q;
        mul_b     = MUL_W'(err_mag);
      end
      ST_MUL_P: begin
        mul_start = !op_started;
        mul_a     = MUL_W'(prop_gain);
        mul_b     = MUL_W'(err_mag);
      end
      ST_MUL_I: begin
        mul_start = !op_started;
        mul_a     = MUL_W'(integ_gain);
        mul_b     = MUL_W'(integ_mag);
      end
      ST_DIV_I: begin
        div_start = !op_started;
        div_n     = mul_prod[DIV_N-1:0];
        div_d     = DIV_D'(MS_PER_S);
      end
      ST_MUL_D: begin
        mul_start = !op_started;
        mul_a     = MUL_W'(deriv_gain);
        mul_b     = MUL_W'(de_mag);
      end
      ST_DIV_D: begin
        div_start = !op_started;
        div_n     = dprod;
        div_d     = dt_q;
      end
      ST_OUT: out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      op_started <= 1'b0;
    end else begin
      state <= state_next;
      if (mul_start || div_start) begin
        op_started <= 1'b1;
      end else if (mul_done || div_done) begin
        op_started <= 1'b0;
      end
    end
  end

  // Controller state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      integ_acc     <= '0;
      prev_err      <= '0;
      prev_pid_time <= '0;
    end else begin
      if (state == ST_IDLE && in_acc && pid_run) begin
        prev_pid_time <= now_ms;
        prev_err      <= err_new;
      end
      if (state == ST_INTEG) begin
        if (isum > signed'({32'b0, lim})) begin
          integ_acc <= signed'(lim);
        end else if (isum < -signed'({32'b0, lim})) begin
          integ_acc <= 20'(-signed'({1'b0, lim}));
        end else begin
          integ_acc <= isum[19:0];
        end
      end
    end
  end

  // Datapath for the tick in progress.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_acc) begin
      err_q      <= err_new;
      de_q       <= 18'(err_new) - 18'(prev_err);
      dt_q       <= now_ms - prev_pid_time;
      auto_q     <= (drive_mode == MODE_AUTO);
      res_right  <= '0;
      res_left   <= '0;
      res_status <= skip_status;
      res_err    <= prev_err;
    end
    if (state == ST_MUL_P && mul_done) begin
      term_p <= err_q[16] ? -signed'(OUT_W'(mul_prod[33:0])) : signed'(OUT_W'(mul_prod[33:0]));
    end
    if (state == ST_DIV_I && div_done) begin
      term_i <= integ_acc[19] ? -signed'(div_q) : signed'(div_q);
    end
    if (state == ST_MUL_D && mul_done) begin
      dprod  <= {mul_prod[DIV_N-11:0], 10'b0} - {mul_prod[DIV_N-5:0], 4'b0}
              - {mul_prod[DIV_N-4:0], 3'b0};
      term_d <= '0;
    end
    if (state == ST_DIV_D && div_done) begin
      term_d <= de_q[17] ? -signed'(div_q) : signed'(div_q);
    end
    if (state == ST_SUM) begin
      res_err <= err_q;
      if ({3'b0, err_mag} <= {10'b0, dead_band}) begin
        res_right  <= '0;
        res_left   <= '0;
        res_status <= auto_q ? STAT_AUTO : STAT_NEUTRAL;
      end else if (!out8[OUT_W-1] && out8 != '0) begin
        res_right  <= duty;
        res_left   <= '0;
        res_status <= (auto_q ? STAT_AUTO : STAT_NEUTRAL) + STAT_RIGHT;
      end else begin
        res_right  <= '0;
        res_left   <= duty;
        res_status <= (auto_q ? STAT_AUTO : STAT_NEUTRAL) + STAT_LEFT;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {7'b0, res_err, res_left, res_right};
      m_tuser <= res_status;
    end
  end

  spid_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  spid_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quot     (div_q)
  );

endmodule

// ===== hdl/spid_checker.sv =====
// Port-level checks for the steering PID H-bridge drive core, bound to the top level.
// Depends on spid_pkg for status codes.
module spid_checker
  import spid_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [3:0]  m_tuser
);

  // A result that is not taken stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // Only one half-bridge is driven at a time.
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:0] == 8'd0 || m_tdata[15:8] == 8'd0))
    else $error("both sides driven");

  // Ticks without a PID step never drive.
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == STAT_PAUSE || m_tuser == STAT_HOLD ||
                 m_tuser == STAT_FAULT || m_tuser == STAT_NO_LINK)
    |-> m_tdata[15:0] == 16'd0)
    else $error("drive while stopped");

  // Status stays at or below its highest code, STAT_NO_LINK.
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= STAT_NO_LINK)
    else $error("bad status code");

endmodule

bind steering_pid_hbridge_drive_core spid_checker u_spid_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
